// ===== hw/rtl/lli_pkg.sv =====
`default_nettype none
package lli_pkg;

  // quotient bits produced by the divider, enough to reach the clamp value
  localparam int DIV_BITS = 34;
  // dividend and divisor widths of the rounding divide
  localparam int NUM_W = 101;
  localparam int DEN_W = 67;
  // largest quotient magnitude kept before the base is added
  localparam logic [DIV_BITS-1:0] QUOT_CAP = 34'h2_0000_0000;

  typedef struct packed {
    logic signed [31:0] a_start_x;
    logic signed [31:0] a_start_y;
    logic signed [31:0] a_start_z;
    logic signed [31:0] a_end_x;
    logic signed [31:0] a_end_y;
    logic signed [31:0] a_end_z;
    logic signed [31:0] b_start_x;
    logic signed [31:0] b_start_y;
    logic signed [31:0] b_end_x;
    logic signed [31:0] b_end_y;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] cross_x;
    logic signed [31:0] cross_y;
    logic signed [31:0] cross_z;
    logic               found;
    logic               saturated;
  } out_word_t;

endpackage
`default_nettype wire

// ===== hw/rtl/lli_div.sv =====
`default_nettype none
// pipelined restoring divide, one quotient bit per stage, then add and clamp
module lli_div (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic [lli_pkg::NUM_W-1:0]  num,
  input  wire logic [lli_pkg::DEN_W-1:0]  den,
  input  wire logic                       ovf,
  input  wire logic                       neg,
  input  wire logic signed [31:0]         base,
  output logic                            out_valid,
  output logic signed [31:0]              value,
  output logic                            sat
);

  localparam int NB = lli_pkg::DIV_BITS;
  localparam int NW = lli_pkg::NUM_W;
  localparam int DW = lli_pkg::DEN_W;

  logic                 vld  [0:NB];
  logic [NW-1:0]        rem  [0:NB];
  logic [NB-1:0]        quo  [0:NB];
  logic [DW-1:0]        dv   [0:NB];
  logic                 ov   [0:NB];
  logic                 ng   [0:NB];
  logic signed [31:0]   bs   [0:NB];

  // stage zero is the input
  assign vld[0] = in_valid;
  assign rem[0] = num;
  assign quo[0] = '0;
  assign dv[0]  = den;
  assign ov[0]  = ovf;
  assign ng[0]  = neg;
  assign bs[0]  = base;

  for (genvar k = 0; k < NB; k++) begin : g_step
    localparam int SH = NB - 1 - k;
    logic [NW-1:0] trial;
    logic [NW:0]   diff;
    logic          ge;

    // trial subtract of the shifted divisor
    assign trial = {{(NW-DW){1'b0}}, dv[k]} << SH;
    assign diff  = {1'b0, rem[k]} - {1'b0, trial};
    assign ge    = !diff[NW];

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
      rem[k+1] <= ge ? diff[NW-1:0] : rem[k];
      quo[k+1] <= {quo[k][NB-2:0], ge};
      dv[k+1]  <= dv[k];
      ov[k+1]  <= ov[k];
      ng[k+1]  <= ng[k];
      bs[k+1]  <= bs[k];
    end
  end

  // clamp quotient, apply sign, add base, saturate
  logic [NB-1:0]      qv;
  logic signed [35:0] sq;
  logic signed [35:0] sum;
  logic               hi_out;

  assign qv     = ov[NB] ? lli_pkg::QUOT_CAP : quo[NB];
  assign sq     = ng[NB] ? -$signed({2'b00, qv}) : $signed({2'b00, qv});
  assign sum    = $signed({{4{bs[NB][31]}}, bs[NB]}) + sq;
  assign hi_out = (sum[35:31] != 5'b00000) && (sum[35:31] != 5'b11111);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[NB];
    end
    if (hi_out) begin
      value <= sum[35] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      value <= sum[31:0];
    end
    sat <= hi_out;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/line_line_intersection_2d.sv =====
`default_nettype none
// channel   ports                    dir   meaning
// item      start, busy, item        in    two lines, each as start and end point
// result    done, result             out   crossing point, found and saturated flags
//
// one word accepted per cycle; busy is high only during reset
// registers in order: input word, differences, cross products, numerator and
// denominator, magnitudes, partial products, their sum, rounding, clamp test,
// the divide (one quotient bit per stage), add and clamp, output word
// synchronous reset clears all valid bits; words in flight are dropped
// results cannot be held off, so the pipeline never stalls
module line_line_intersection_2d (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire lli_pkg::in_word_t item,
  output logic                   done,
  output lli_pkg::out_word_t     result
);

  localparam int PRE = 9;
  localparam int TOT = PRE + lli_pkg::DIV_BITS + 1;
  localparam int NW  = lli_pkg::NUM_W;
  localparam int DW  = lli_pkg::DEN_W;

  assign busy = rst;

  logic                take;
  logic [PRE:1]        v;
  lli_pkg::in_word_t   wq [1:TOT];
  logic                fq [5:TOT];

  assign take = start && !busy;

  // valid bits of the front stages
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[PRE-1:1], take};
    end
  end

  // stage 2: direction differences
  logic signed [32:0] ax, ay, bx, by, cx, cy;
  always_ff @(posedge clk) begin
    ax <= {wq[1].a_end_x[31], wq[1].a_end_x} - {wq[1].a_start_x[31], wq[1].a_start_x};
    ay <= {wq[1].a_end_y[31], wq[1].a_end_y} - {wq[1].a_start_y[31], wq[1].a_start_y};
    bx <= {wq[1].b_start_x[31], wq[1].b_start_x} - {wq[1].b_end_x[31], wq[1].b_end_x};
    by <= {wq[1].b_start_y[31], wq[1].b_start_y} - {wq[1].b_end_y[31], wq[1].b_end_y};
    cx <= {wq[1].a_start_x[31], wq[1].a_start_x} - {wq[1].b_start_x[31], wq[1].b_start_x};
    cy <= {wq[1].a_start_y[31], wq[1].a_start_y} - {wq[1].b_start_y[31], wq[1].b_start_y};
  end

  // stage 3: cross products
  logic signed [65:0] p_bycx, p_bxcy, p_aybx, p_axby;
  logic signed [32:0] ax3, ay3;
  always_ff @(posedge clk) begin
    p_bycx <= by * cx;
    p_bxcy <= bx * cy;
    p_aybx <= ay * bx;
    p_axby <= ax * by;
    ax3    <= ax;
    ay3    <= ay;
  end

  // stage 4: numerator and denominator
  logic signed [66:0] dd, ff;
  logic signed [32:0] ax4, ay4;
  always_ff @(posedge clk) begin
    dd  <= {p_bycx[65], p_bycx} - {p_bxcy[65], p_bxcy};
    ff  <= {p_aybx[65], p_aybx} - {p_axby[65], p_axby};
    ax4 <= ax3;
    ay4 <= ay3;
  end

  // input word and crossing flag travel beside the arithmetic
  always_ff @(posedge clk) begin
    wq[1] <= item;
    for (int k = 2; k <= TOT; k++) begin
      wq[k] <= wq[k-1];
    end
    fq[5] <= (ff != 67'sd0);
    for (int k = 6; k <= TOT; k++) begin
      fq[k] <= fq[k-1];
    end
  end

  // stage 5: magnitudes and signs
  logic [DW-1:0] dm, fm5;
  logic [32:0]   axm, aym;
  logic          ngx5, ngy5;
  always_ff @(posedge clk) begin
    dm    <= dd[66] ? (~dd + 67'd1) : dd;
    fm5   <= ff[66] ? (~ff + 67'd1) : ff;
    axm   <= ax4[32] ? (~ax4 + 33'd1) : ax4;
    aym   <= ay4[32] ? (~ay4 + 33'd1) : ay4;
    ngx5  <= dd[66] ^ ax4[32] ^ ff[66];
    ngy5  <= dd[66] ^ ay4[32] ^ ff[66];
  end

  // stage 6: partial products of numerator times direction
  logic [66:0] plx, ply;
  logic [65:0] phx, phy;
  logic [DW-1:0] fm6;
  logic          ngx6, ngy6;
  always_ff @(posedge clk) begin
    plx  <= dm[33:0] * axm;
    phx  <= dm[66:34] * axm;
    ply  <= dm[33:0] * aym;
    phy  <= dm[66:34] * aym;
    fm6  <= fm5;
    ngx6 <= ngx5;
    ngy6 <= ngy5;
  end

  // stage 7: combine partial products
  logic [NW-1:0] nx7, ny7;
  logic [DW-1:0] fm7;
  logic          ngx7, ngy7;
  always_ff @(posedge clk) begin
    nx7  <= {34'b0, plx} + {1'b0, phx, 34'b0};
    ny7  <= {34'b0, ply} + {1'b0, phy, 34'b0};
    fm7  <= fm6;
    ngx7 <= ngx6;
    ngy7 <= ngy6;
  end

  // stage 8: add half the divisor for round to nearest
  logic [NW-1:0] nx8, ny8;
  logic [DW-1:0] fm8;
  logic          ngx8, ngy8;
  always_ff @(posedge clk) begin
    nx8  <= nx7 + {35'b0, fm7[DW-1:1]};
    ny8  <= ny7 + {35'b0, fm7[DW-1:1]};
    fm8  <= fm7;
    ngx8 <= ngx7;
    ngy8 <= ngy7;
  end

  // stage 9: quotient above the clamp value
  logic [NW-1:0] lim;
  logic [NW-1:0] nx9, ny9;
  logic [DW-1:0] fm9;
  logic          ngx9, ngy9, ovx9, ovy9;
  assign lim = {1'b0, fm8, 33'b0} + {34'b0, fm8};
  always_ff @(posedge clk) begin
    nx9  <= nx8;
    ny9  <= ny8;
    fm9  <= fm8;
    ngx9 <= ngx8;
    ngy9 <= ngy8;
    ovx9 <= (nx8 >= lim);
    ovy9 <= (ny8 >= lim);
  end

  // per axis divide, add and clamp
  logic               vx, vy, sx, sy;
  logic signed [31:0] qx, qy;

  lli_div u_div_x (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[PRE]),
    .num       (nx9),
    .den       (fm9),
    .ovf       (ovx9),
    .neg       (ngx9),
    .base      (wq[PRE].a_start_x),
    .out_valid (vx),
    .value     (qx),
    .sat       (sx)
  );

  lli_div u_div_y (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[PRE]),
    .num       (ny9),
    .den       (fm9),
    .ovf       (ovy9),
    .neg       (ngy9),
    .base      (wq[PRE].a_start_y),
    .out_valid (vy),
    .value     (qy),
    .sat       (sy)
  );

  // output word; parallel lines give the end point of the first line
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vx;
    end
    if (fq[TOT]) begin
      result.cross_x   <= qx;
      result.cross_y   <= qy;
      result.cross_z   <= wq[TOT].a_start_z;
      result.found     <= 1'b1;
      result.saturated <= sx || sy;
    end else begin
      result.cross_x   <= wq[TOT].a_end_x;
      result.cross_y   <= wq[TOT].a_end_y;
      result.cross_z   <= wq[TOT].a_end_z;
      result.found     <= 1'b0;
      result.saturated <= 1'b0;
    end
  end

`ifndef SYNTH
  // both axis dividers stay in step
  a_axis_lock: assert property (@(posedge clk) disable iff (rst) vx == vy)
    else $error("axis dividers out of step");

  // every accepted word comes out after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    take |-> ##(TOT + 1) done)
    else $error("result missing after accept");

  // parallel lines never report saturation
  a_par_nosat: assert property (@(posedge clk) disable iff (rst)
    done && !result.found |-> !result.saturated)
    else $error("saturated set on parallel lines");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_line_line_intersection_2d.sv =====
`timescale 1ns / 1ps

module tb_line_line_intersection_2d;

  localparam int LATENCY = 45;
  localparam int N_RANDOM = 530;
  localparam longint CYCLE_LIMIT = 400000;

  // expected crossing results, oldest first
  class crossing_board;
    lli_pkg::out_word_t pending[$];
    int errors;
    int checked;

    // signed 128-bit two's complement arithmetic for the crossing math
    function automatic lli_pkg::out_word_t predict(lli_pkg::in_word_t w);
      logic signed [127:0] ax, ay, bx, by, cx, cy, d, f;
      logic signed [127:0] num, n, m, q, v;
      logic signed [127:0] base[2];
      logic signed [127:0] dir[2];
      logic signed [31:0] res[2];
      logic sat;
      lli_pkg::out_word_t r;
      ax = 128'(w.a_end_x) - 128'(w.a_start_x);
      ay = 128'(w.a_end_y) - 128'(w.a_start_y);
      bx = 128'(w.b_start_x) - 128'(w.b_end_x);
      by = 128'(w.b_start_y) - 128'(w.b_end_y);
      cx = 128'(w.a_start_x) - 128'(w.b_start_x);
      cy = 128'(w.a_start_y) - 128'(w.b_start_y);
      d = by * cx - bx * cy;
      f = ay * bx - ax * by;
      if (f == 0) begin
        r.cross_x = w.a_end_x;
        r.cross_y = w.a_end_y;
        r.cross_z = w.a_end_z;
        r.found = 1'b0;
        r.saturated = 1'b0;
        return r;
      end
      base[0] = 128'(w.a_start_x);
      base[1] = 128'(w.a_start_y);
      dir[0] = ax;
      dir[1] = ay;
      sat = 1'b0;
      for (int k = 0; k < 2; k++) begin
        num = d * dir[k];
        n = (num < 0) ? -num : num;
        m = (f < 0) ? -f : f;
        // round to nearest, ties away from zero, then cap magnitude
        q = (n + (m >>> 1)) / m;
        if (q > 128'sh2_0000_0000) q = 128'sh2_0000_0000;
        if ((num < 0) != (f < 0)) q = -q;
        v = base[k] + q;
        if (v > 128'sd2147483647) begin
          v = 128'sd2147483647;
          sat = 1'b1;
        end
        if (v < -128'sd2147483648) begin
          v = -128'sd2147483648;
          sat = 1'b1;
        end
        res[k] = v[31:0];
      end
      r.cross_x = res[0];
      r.cross_y = res[1];
      r.cross_z = w.a_start_z;
      r.found = 1'b1;
      r.saturated = sat;
      return r;
    endfunction

    function void note_item(lli_pkg::in_word_t w);
      pending.push_back(predict(w));
    endfunction

    function void check_result(lli_pkg::out_word_t got);
      lli_pkg::out_word_t exp_w;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.cross_x !== exp_w.cross_x || got.cross_y !== exp_w.cross_y ||
          got.cross_z !== exp_w.cross_z || got.found !== exp_w.found ||
          got.saturated !== exp_w.saturated) begin
        $display("%0t: mismatch expected x=%h y=%h z=%h f=%b s=%b", $time,
                 exp_w.cross_x, exp_w.cross_y, exp_w.cross_z, exp_w.found,
                 exp_w.saturated);
        $display("%0t:          actual   x=%h y=%h z=%h f=%b s=%b", $time,
                 got.cross_x, got.cross_y, got.cross_z, got.found, got.saturated);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  lli_pkg::in_word_t item = '0;
  logic done;
  lli_pkg::out_word_t result;
  crossing_board board;
  longint cycles = 0;
  int n_parallel = 0;
  int n_sat = 0;

  line_line_intersection_2d u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .item(item), .done(done), .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result monitor and cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) begin
      if (!result.found) n_parallel++;
      if (result.saturated) n_sat++;
      board.check_result(result);
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("[line_line_intersection_2d] ERROR");
      $finish;
    end
  end

  // one word per handshake; start held high across back-to-back words
  task automatic send_word(lli_pkg::in_word_t w, bit last_of_burst);
    start <= 1'b1;
    item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    board.note_item(w);
    if (last_of_burst) start <= 1'b0;
  endtask

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  function automatic logic [31:0] rand_coord();
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7fff_ffff - $urandom_range(0, 3);
      2, 3: return 32'($signed($urandom_range(0, 2000)) - 1000) <<< 16;
      4, 5: return 32'($signed($urandom_range(0, 65535)) - 32768);
      default: return $urandom();
    endcase
  endfunction

  function automatic lli_pkg::in_word_t rand_word();
    lli_pkg::in_word_t w;
    w.a_start_x = rand_coord();
    w.a_start_y = rand_coord();
    w.a_start_z = $urandom();
    w.a_end_x = rand_coord();
    w.a_end_y = rand_coord();
    w.a_end_z = $urandom();
    w.b_start_x = rand_coord();
    w.b_start_y = rand_coord();
    w.b_end_x = rand_coord();
    w.b_end_y = rand_coord();
    case ($urandom_range(0, 7))
      // parallel: second direction equals the first
      0: begin
        w.b_end_x = w.b_start_x + (w.a_end_x - w.a_start_x);
        w.b_end_y = w.b_start_y + (w.a_end_y - w.a_start_y);
      end
      // degenerate first line
      1: begin
        w.a_end_x = w.a_start_x;
        w.a_end_y = w.a_start_y;
      end
      // nearly parallel, drives the quotient out of range
      2: begin
        w.b_end_x = w.b_start_x + (w.a_end_x - w.a_start_x) + 1;
        w.b_end_y = w.b_start_y + (w.a_end_y - w.a_start_y);
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic lli_pkg::in_word_t make_word(int ax0, int ay0, int ax1, int ay1,
                                                  int bx0, int by0, int bx1, int by1);
    lli_pkg::in_word_t w;
    w.a_start_x = ax0; w.a_start_y = ay0; w.a_start_z = 32'h1234_5678;
    w.a_end_x = ax1; w.a_end_y = ay1; w.a_end_z = 32'h9abc_def0;
    w.b_start_x = bx0; w.b_start_y = by0; w.b_end_x = bx1; w.b_end_y = by1;
    return w;
  endfunction

  task automatic drain();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  initial begin
    lli_pkg::in_word_t dir_words[$];
    lli_pkg::in_word_t w;
    int g;
    board = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed words: crossings, parallel, coincident, degenerate, extremes
    dir_words.push_back(make_word(0, 0, 65536, 65536, 0, 65536, 65536, 0));
    dir_words.push_back(make_word(0, 0, 65536, 0, 0, 65536, 65536, 65536));
    dir_words.push_back(make_word(0, 0, 65536, 0, 0, 0, 131072, 0));
    dir_words.push_back(make_word(5, 5, 5, 5, 1, 2, 3, 4));
    dir_words.push_back(make_word(1, 2, 3, 4, 7, 7, 7, 7));
    dir_words.push_back(make_word(0, 0, 3, 1, 0, 1, 1, 0));
    dir_words.push_back(make_word(0, 0, 3, -1, 0, -1, 1, 0));
    dir_words.push_back(make_word(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                                  32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                                  32'h7fff_ffff, 32'h8000_0000));
    dir_words.push_back(make_word(32'h8000_0000, 0, 32'h7fff_ffff, 1,
                                  32'h8000_0000, 0, 32'h7fff_ffff, 0));
    dir_words.push_back(make_word(0, 0, 32'h7fff_ffff, 1, 0, 0, 32'h7fff_ffff, 2));
    dir_words.push_back(make_word(32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h7fff_ffff, 32'h8000_0001));
    dir_words.push_back(make_word(-1, -1, 0, 0, -1, 0, 0, -1));
    dir_words.push_back(make_word(32'hffff_ffff, 32'h0, 32'h0, 32'hffff_ffff,
                                  32'h5555_5555, 32'haaaa_aaaa, 32'haaaa_aaaa,
                                  32'h5555_5555));
    w = make_word(0, 0, 0, 0, 0, 0, 0, 0);
    w.a_start_z = 32'hffff_ffff;
    w.a_end_z = 32'h8000_0000;
    dir_words.push_back(w);
    foreach (dir_words[i]) send_word(dir_words[i], i == dir_words.size() - 1);

    // hold off until the pipeline is empty
    drain();

    for (int i = 0; i < N_RANDOM; i++) begin
      g = gap_len();
      send_word(rand_word(), g != 0);
      repeat (g) @(posedge clk);
      if (i == N_RANDOM / 2) begin
        start <= 1'b0;
        drain();
      end
    end
    start <= 1'b0;

    fork
      drain();
      repeat (20 * LATENCY) @(posedge clk);
    join_any
    disable fork;
    repeat (LATENCY + 5) @(posedge clk);

    $display("checked %0d results: %0d parallel or degenerate, %0d clamped",
             board.checked, n_parallel, n_sat);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("[line_line_intersection_2d] OK");
    end else begin
      $display("%0d mismatches, %0d results missing", board.errors,
               board.pending.size());
      $display("[line_line_intersection_2d] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lli_pkg.sv
hw/rtl/lli_div.sv
hw/rtl/line_line_intersection_2d.sv
tb/tb_line_line_intersection_2d.sv
